[sv/dttl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttl_pkg: shared types and constants
// Field structs, result kinds and sizes for the delayed task timer list.
// ----------------------------------------------------------------------------
package dttl_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = 6;

    localparam logic       ACT_ADD      = 1'b0;
    localparam logic       ACT_TICK     = 1'b1;
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    typedef struct packed {
        logic        action;
        logic [15:0] task_id;
        logic [31:0] delay;
        logic [31:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] fired_id;
        logic        status;
        logic [5:0]  zero_delay_count;
        logic        last;
    } out_item_t;

    // one stored task
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] delay;
        logic [31:0] elapsed;
    } entry_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic        load;     // write tail cell with add data
        logic        rotate;   // shift chain by one toward head
        logic        keep;     // head entry goes back into the ring
        logic [31:0] interval;
    } cell_ctrl_t;

endpackage

[sv/delayed_task_timer_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_task_timer_list: list of pending one-shot tasks
// Cell chain of CAPACITY entries with a tick sequencer at the head.
// ----------------------------------------------------------------------------
// An add request returns one acknowledge. A tick request rotates the whole
// chain once through the head cell, one cell per cycle while no fired result
// is stalled at the output; each head entry is updated, fired or written back
// behind the entries already kept, so the survivors end up packed at the head
// in their old order. Fired results come in list order, then one summary. No
// clearing pass after reset.
module delayed_task_timer_list (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dttl_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dttl_pkg::out_item_t  m_data
);
    import dttl_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_SUM} state_t;

    localparam logic [CNT_W-1:0] CAP   = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LASTP = CNT_W'(CAPACITY - 1);

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg, wr_reg, pos_reg, zeros_reg;
    logic [31:0]      last_time_reg, interval_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    cell_ctrl_t ctrl;
    entry_t     q [CAPACITY];
    entry_t     prev [CAPACITY];
    entry_t     add_entry, head, upd;
    logic [32:0] sum;
    logic        active, fire, out_free, step;
    logic [CNT_W-1:0] keep_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;

    // head entry after adding the interval, saturated
    assign head   = q[0];
    assign sum    = {1'b0, head.elapsed} + {1'b0, interval_reg};
    assign active = pos_reg < count_reg;
    assign fire   = active && ((sum[32] ? 32'hFFFF_FFFF : sum[31:0]) >= head.delay);
    assign step   = (state_reg == ST_WALK) && (out_free || !fire);

    always_comb begin
        upd         = head;
        upd.elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end

    assign add_entry = '{id: s_data.task_id, delay: s_data.delay, elapsed: 32'd0};

    // cell that lands on slot wr once the remaining rotations are done
    assign keep_idx = wr_reg + LASTP - pos_reg;

    // ring wiring: a kept head entry drops in right behind the survivors
    always_comb begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
            if (ctrl.keep && (keep_idx == CNT_W'(i))) begin
                prev[i] = upd;
            end else begin
                prev[i] = q[i+1];
            end
        end
        prev[CAPACITY-1] = upd;
    end

    assign ctrl.load     = s_valid && s_ready && (s_data.action == ACT_ADD)
                           && (count_reg < CAP);
    assign ctrl.rotate   = step;
    assign ctrl.keep     = active && !fire;
    assign ctrl.interval = interval_reg;

    // add writes slot count; chain rotated back so slot index equals position
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            dttl_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .is_tail   (count_reg == CNT_W'(g)),
                .from_prev (prev[g]),
                .add_entry (add_entry),
                .q         (q[g])
            );
        end
    endgenerate

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_time_reg <= '0;
            m_valid_reg   <= 1'b0;
            wr_reg        <= '0;
            pos_reg       <= '0;
            zeros_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        if (s_data.action == ACT_ADD) begin
                            if (count_reg < CAP) begin
                                count_reg <= count_reg + 1'b1;
                            end
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= '{kind: KIND_ACK, fired_id: 16'd0,
                                             status: !(count_reg < CAP),
                                             zero_delay_count: '0, last: 1'b1};
                        end else begin
                            interval_reg  <= s_data.now_time - last_time_reg;
                            last_time_reg <= s_data.now_time;
                            wr_reg        <= '0;
                            pos_reg       <= '0;
                            zeros_reg     <= '0;
                            state_reg     <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (step) begin
                        if (active && head.delay == 32'd0) begin
                            zeros_reg <= zeros_reg + 1'b1;
                        end
                        if (fire) begin
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= '{kind: KIND_FIRED, fired_id: head.id,
                                             status: 1'b0, zero_delay_count: '0,
                                             last: 1'b0};
                        end else if (active) begin
                            wr_reg <= wr_reg + 1'b1;
                        end
                        pos_reg <= pos_reg + 1'b1;
                        if (pos_reg == LASTP) begin
                            state_reg <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    if (out_free) begin
                        count_reg   <= wr_reg;
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{kind: KIND_SUMMARY, fired_id: 16'd0,
                                         status: 1'b0, zero_delay_count: zeros_reg,
                                         last: 1'b1};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[sv/dttl_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttl_cell: one storage cell of the task chain
// Holds one entry and hands it to its head-side neighbor on a rotate.
// ----------------------------------------------------------------------------
module dttl_cell (
    input  logic                aclk,
    input  dttl_pkg::cell_ctrl_t ctrl,
    input  logic                is_tail,
    input  dttl_pkg::entry_t    from_prev,
    input  dttl_pkg::entry_t    add_entry,
    output dttl_pkg::entry_t    q
);
    import dttl_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    // select load, shift or hold
    always_comb begin
        ent_next = ent_reg;
        if (ctrl.rotate) begin
            ent_next = from_prev;
        end else if (ctrl.load && is_tail) begin
            ent_next = add_entry;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign q = ent_reg;

endmodule

[sv/dttl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttl_checker: port-level checks for the timer list
// Watches request and result handshakes of the top level.
// ----------------------------------------------------------------------------
module dttl_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input dttl_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input dttl_pkg::out_item_t m_data
);
    import dttl_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // never report an unused kind
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.kind != 2'd3)
        else $error("bad result kind");

    // fired results are never last, ack and summary always are
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.kind != KIND_FIRED)))
        else $error("last flag mismatch");

    // an accepted add gets its acknowledge next cycle
    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_ADD |=>
        m_valid && m_data.kind == KIND_ACK)
        else $error("missing acknowledge");

endmodule

bind delayed_task_timer_list dttl_checker u_dttl_checker (.*);
